// ===== hdl/bppm_pkg.sv =====
// shared types and constants for the buffer pool pin manager
// no dependencies; imported by bppm_frame_ram, buffer_pool_pin_manager_unit and its test bench
`timescale 1ns / 1ps

package bppm_pkg;

   localparam int NUM_FRAMES = 16;
   localparam int FRAME_W    = 4;
   localparam int TAG_W      = 32;
   localparam int PIN_W      = 8;
   localparam int AVAIL_W    = 5;
   localparam int SCAN_W     = $clog2(NUM_FRAMES + 1);

   localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   localparam logic CMD_PIN   = 1'b0;
   localparam logic CMD_UNPIN = 1'b1;

   typedef logic [FRAME_W-1:0] frame_idx_type;
   typedef logic [PIN_W-1:0]   pin_type;
   typedef logic [TAG_W-1:0]   tag_type;
   typedef logic [AVAIL_W-1:0] avail_type;

   typedef struct packed {
      tag_type tag;
      pin_type pins;
   } entry_type;

endpackage

// ===== hdl/bppm_frame_ram.sv =====
// frame table memory: block tag and pin count per frame
// one write port, one read port, registered read data; uses bppm_pkg
`timescale 1ns / 1ps

module bppm_frame_ram (
   input  logic                   clock,
   input  logic                   wr_en,
   input  bppm_pkg::frame_idx_type wr_addr,
   input  bppm_pkg::entry_type    wr_data,
   input  bppm_pkg::frame_idx_type rd_addr,
   output bppm_pkg::entry_type    rd_data
);
   import bppm_pkg::*;

   entry_type mem [NUM_FRAMES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/buffer_pool_pin_manager_unit.sv =====
// buffer pool pin manager: pin/unpin requests against a pool of frames
// depends on bppm_pkg and bppm_frame_ram
`timescale 1ns / 1ps
//
//   channel   direction  ports                 payload
//   req       in         req_tvalid/tready     tuser: command; tdata: block_id, frame_index
//   rsp       out        rsp_tvalid/tready     tdata: ok, frame, hit, load_needed,
//                                              available_count
//
// a pin reads every frame, one memory read per frame over the single read port of
// the frame table, whose read data is registered; it then decides and writes back,
// and the next request is taken once the unit is back in idle
// an unpin reads the frame, then decides and writes back
// reset clears the valid bits, which also stand for a zero pin count, so the
// table needs no clearing pass; the unpinned count resets to the pool size
// a new request is taken while the last result still waits on rsp_tready;
// the decide step holds until the result register is free

module buffer_pool_pin_manager_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic                                 req_tuser,   // [0] command
   input  logic [bppm_pkg::REQ_DATA_W-1:0]      req_tdata,   // [31:0] block_id,
                                                             // [35:32] frame_index, rest zero
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bppm_pkg::RSP_DATA_W-1:0]      rsp_tdata    // [0] ok, [4:1] frame, [5] hit,
                                                             // [6] load_needed,
                                                             // [11:7] available_count, rest zero
);
   import bppm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UNPIN_RD,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic          cmd_ff, cmd_in;
   tag_type       blk_ff, blk_in;
   frame_idx_type idx_ff, idx_in;

   // scan progress and findings
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              hit_found_ff, hit_found_in;
   frame_idx_type     hit_idx_ff, hit_idx_in;
   pin_type           hit_cnt_ff, hit_cnt_in;
   logic              free_found_ff, free_found_in;
   frame_idx_type     free_idx_ff, free_idx_in;

   // pool state outside the table
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;
   avail_type             avail_ff, avail_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_ok_ff, rsp_ok_in;
   frame_idx_type rsp_frame_ff, rsp_frame_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic          rsp_load_ff, rsp_load_in;
   avail_type     rsp_avail_ff, rsp_avail_in;

   // table port
   logic          wr_en;
   frame_idx_type wr_addr;
   entry_type     wr_data;
   frame_idx_type rd_addr;
   entry_type     rd_data;

   logic [SCAN_W-1:0] scan_m1;
   frame_idx_type     eval_idx;
   pin_type           eval_cnt;
   pin_type           unpin_cnt;
   logic              out_free;
   logic              pick_ok;
   frame_idx_type     pick_idx;
   pin_type           pick_cnt;

   bppm_frame_ram u_frame_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // read address: the scan counter while scanning, the latched frame otherwise
   assign rd_addr = (state_ff == ST_SCAN) ? scan_ff[FRAME_W-1:0] : idx_ff;

   // data arriving now belongs to the previous scan address
   assign scan_m1  = scan_ff - SCAN_W'(1);
   assign eval_idx = scan_m1[FRAME_W-1:0];
   // a frame never pinned holds no count in the table
   assign eval_cnt  = valid_ff[eval_idx] ? rd_data.pins : '0;
   assign unpin_cnt = valid_ff[idx_ff] ? rd_data.pins : '0;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // resident frame wins over the first unpinned one
   always_comb begin
      pick_ok  = 1'b1;
      pick_idx = hit_idx_ff;
      pick_cnt = hit_cnt_ff;
      priority if (hit_found_ff) begin
         pick_ok = 1'b1;
      end else if (free_found_ff) begin
         pick_idx = free_idx_ff;
         pick_cnt = '0;
      end else begin
         pick_ok = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      blk_in        = blk_ff;
      idx_in        = idx_ff;
      scan_in       = scan_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_cnt_in    = hit_cnt_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      avail_in      = avail_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_load_in   = rsp_load_ff;
      rsp_avail_in  = rsp_avail_ff;
      wr_en         = 1'b0;
      wr_addr       = pick_idx;
      wr_data       = '{tag: blk_ff, pins: pick_cnt + PIN_W'(1)};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in        = req_tuser;
               blk_in        = req_tdata[TAG_W-1:0];
               idx_in        = req_tdata[TAG_W +: FRAME_W];
               scan_in       = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = (req_tuser == CMD_UNPIN) ? ST_UNPIN_RD : ST_SCAN;
            end
         end

         ST_SCAN: begin
            scan_in = scan_ff + SCAN_W'(1);
            if (scan_ff != '0) begin
               if (!hit_found_ff && valid_ff[eval_idx] && rd_data.tag == blk_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = eval_idx;
                  hit_cnt_in   = rd_data.pins;
               end
               if (!free_found_ff && eval_cnt == '0) begin
                  free_found_in = 1'b1;
                  free_idx_in   = eval_idx;
               end
            end
            if (scan_ff == SCAN_W'(NUM_FRAMES)) begin
               state_in = ST_DECIDE;
            end
         end

         ST_UNPIN_RD: begin
            state_in = ST_DECIDE;
         end

         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_load_in  = 1'b0;
               state_in     = ST_IDLE;
               if (cmd_ff == CMD_PIN) begin
                  if (pick_ok && pick_cnt != PIN_MAX) begin
                     wr_en              = 1'b1;
                     valid_in[pick_idx] = 1'b1;
                     if (pick_cnt == '0 && avail_ff != '0) begin
                        avail_in = avail_ff - AVAIL_W'(1);
                     end
                     rsp_ok_in    = 1'b1;
                     rsp_frame_in = pick_idx;
                     rsp_hit_in   = hit_found_ff;
                     rsp_load_in  = !hit_found_ff;
                  end else begin
                     rsp_ok_in    = 1'b0;
                     rsp_frame_in = '0;
                  end
               end else begin
                  rsp_frame_in = idx_ff;
                  if (unpin_cnt != '0) begin
                     wr_en     = 1'b1;
                     wr_addr   = idx_ff;
                     wr_data   = '{tag: rd_data.tag, pins: unpin_cnt - PIN_W'(1)};
                     rsp_ok_in = 1'b1;
                     if (unpin_cnt == PIN_W'(1)) begin
                        avail_in = avail_ff + AVAIL_W'(1);
                     end
                  end else begin
                     rsp_ok_in = 1'b0;
                  end
               end
               rsp_avail_in = avail_in;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         avail_ff      <= AVAIL_W'(NUM_FRAMES);
         rsp_valid_ff  <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         scan_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         avail_ff      <= avail_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         scan_ff       <= scan_in;
      end
      cmd_ff       <= cmd_in;
      blk_ff       <= blk_in;
      idx_ff       <= idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_cnt_ff   <= hit_cnt_in;
      free_idx_ff  <= free_idx_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_load_ff  <= rsp_load_in;
      rsp_avail_ff <= rsp_avail_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_avail_ff, rsp_load_ff, rsp_hit_ff,
                        rsp_frame_ff, rsp_ok_ff};

endmodule

// ===== tb/buffer_pool_pin_manager_unit_test.sv =====
// self-checking bench for buffer_pool_pin_manager_unit: pin and unpin traffic
// checked item by item against a behavioral model of the frame pool
// depends on bppm_pkg and the buffer_pool_pin_manager_unit rtl
`timescale 1ns / 1ps

module buffer_pool_pin_manager_unit_test;

   import bppm_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 190;
   localparam int HOT_BLOCKS   = 20;    // a few more ids than frames

   // one result item as the bench sees it
   typedef struct packed {
      logic          ok;
      frame_idx_type frame;
      logic          hit;
      logic          load_needed;
      avail_type     available_count;
   } pool_result_type;

   // one row of the directed table
   typedef struct {
      logic            cmd;
      tag_type         blk;
      frame_idx_type   idx;
      logic            typed;    // expectation written into the row
      pool_result_type want;
   } stim_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = CMD_PIN;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // model of the pool
   logic      frame_in_use [NUM_FRAMES];
   tag_type   frame_tag    [NUM_FRAMES];
   pin_type   frame_pins   [NUM_FRAMES];
   avail_type free_frames;

   pool_result_type pending_results[$];
   stim_row_type    directed_rows[$];
   tag_type         hot_blocks[HOT_BLOCKS];

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int error_count     = 0;
   int cycle_count     = 0;
   int items_sent      = 0;
   int results_seen    = 0;
   int pin_hits        = 0;
   int pin_loads       = 0;
   int pins_refused    = 0;
   int unpins_done     = 0;
   int unpins_refused  = 0;

   buffer_pool_pin_manager_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   // receiver stalls, decided once per cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // apply one request to the pool model and return its result
   function automatic pool_result_type apply_pool_request(input logic cmd, input tag_type blk,
                                                          input frame_idx_type idx);
      pool_result_type r;
      int              found;
      logic            is_hit;
      r      = '0;
      found  = -1;
      is_hit = 1'b0;
      if (cmd == CMD_PIN) begin
         // resident block wins, whatever its pin count
         for (int i = 0; i < NUM_FRAMES; i++) begin
            if (found < 0 && frame_in_use[i] && frame_tag[i] == blk) begin
               found  = i;
               is_hit = 1'b1;
            end
         end
         // otherwise the lowest frame with no pins
         for (int i = 0; i < NUM_FRAMES; i++) begin
            if (found < 0 && frame_pins[i] == '0) found = i;
         end
         if (found < 0 || frame_pins[found] == PIN_MAX) begin
            pins_refused++;
         end else begin
            if (!is_hit) begin
               frame_in_use[found] = 1'b1;
               frame_tag[found]    = blk;
               pin_loads++;
            end else begin
               pin_hits++;
            end
            if (frame_pins[found] == '0) free_frames--;
            frame_pins[found]++;
            r.ok          = 1'b1;
            r.frame       = frame_idx_type'(found);
            r.hit         = is_hit;
            r.load_needed = !is_hit;
         end
      end else begin
         r.frame = idx;
         if (frame_pins[idx] != '0) begin
            frame_pins[idx]--;
            if (frame_pins[idx] == '0) free_frames++;
            r.ok = 1'b1;
            unpins_done++;
         end else begin
            unpins_refused++;
         end
      end
      r.available_count = free_frames;
      return r;
   endfunction

   // present one item, entered and left at a falling edge
   task automatic send_request(input logic cmd, input tag_type blk, input frame_idx_type idx,
                               input logic typed, input pool_result_type want,
                               output pool_result_type predicted);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, idx, blk};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_pool_request(cmd, blk, idx);
      pending_results.push_back(typed ? want : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic add_row(input logic cmd, input tag_type blk, input frame_idx_type idx,
                          input logic typed, input logic ok, input frame_idx_type frame,
                          input logic hit, input logic load_needed, input avail_type avail);
      stim_row_type row;
      row.cmd  = cmd;
      row.blk  = blk;
      row.idx  = idx;
      row.typed = typed;
      row.want = '{ok, frame, hit, load_needed, avail};
      directed_rows.push_back(row);
   endtask

   // pick a random request: mostly a working set a bit larger than the pool,
   // with unpins aimed at frames that hold pins, plus noise
   task automatic pick_random_request(output logic cmd, output tag_type blk,
                                      output frame_idx_type idx);
      int roll;
      int start;
      roll  = $urandom_range(99);
      start = $urandom_range(NUM_FRAMES - 1);
      cmd   = CMD_PIN;
      blk   = $urandom;
      idx   = frame_idx_type'($urandom_range(NUM_FRAMES - 1));
      if (roll < 45) begin
         blk = hot_blocks[$urandom_range(HOT_BLOCKS - 1)];
      end else if (roll < 55) begin
         // fresh block id, every bit random
      end else if (roll < 92) begin
         cmd = CMD_UNPIN;
         for (int k = NUM_FRAMES - 1; k >= 0; k--) begin
            if (frame_pins[(start + k) % NUM_FRAMES] != '0)
               idx = frame_idx_type'((start + k) % NUM_FRAMES);
         end
      end else begin
         cmd = CMD_UNPIN;
      end
   endtask

   // result checker
   always @(posedge clock) begin
      pool_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("result item 0x%h with nothing expected", rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            // tdata: [0] ok, [4:1] frame, [5] hit, [6] load_needed, [11:7] available_count
            if (rsp_tdata[0] !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[4:1] !== want.frame) begin
               $error("frame: expected %0d, got %0d", want.frame, rsp_tdata[4:1]);
               error_count++;
            end
            if (rsp_tdata[5] !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_tdata[5]);
               error_count++;
            end
            if (rsp_tdata[6] !== want.load_needed) begin
               $error("load_needed: expected %0d, got %0d", want.load_needed, rsp_tdata[6]);
               error_count++;
            end
            if (rsp_tdata[11:7] !== want.available_count) begin
               $error("available_count: expected %0d, got %0d", want.available_count,
                      rsp_tdata[11:7]);
               error_count++;
            end
            if (rsp_tdata[RSP_DATA_W-1:12] !== '0) begin
               $error("padding: expected 0, got 0x%h", rsp_tdata[RSP_DATA_W-1:12]);
               error_count++;
            end
         end
      end
   end

   // stimulus
   initial begin
      pool_result_type predicted;
      pool_result_type got_first;
      logic            cmd;
      tag_type         blk;
      frame_idx_type   idx;
      tag_type         hammer_block;
      frame_idx_type   hammer_frame;
      int              phase_idle[4];
      int              phase_stall[4];

      phase_idle  = '{0, 84, 0, 38};
      phase_stall = '{0, 0, 84, 38};

      for (int i = 0; i < NUM_FRAMES; i++) begin
         frame_in_use[i] = 1'b0;
         frame_tag[i]    = '0;
         frame_pins[i]   = '0;
      end
      free_frames = avail_type'(NUM_FRAMES);

      hot_blocks[0] = '0;
      hot_blocks[1] = '1;
      for (int i = 2; i < HOT_BLOCKS; i++) hot_blocks[i] = $urandom;

      // directed table: typed rows are read straight off the pool rules
      // unpin of frames with no pins, on an empty pool
      add_row(CMD_UNPIN, '0, 4'd15, 1'b1, 1'b0, 4'd15, 1'b0, 1'b0, 5'd16);
      add_row(CMD_UNPIN, '1, 4'd0,  1'b1, 1'b0, 4'd0,  1'b0, 1'b0, 5'd16);
      // first loads, lowest block id and highest block id
      add_row(CMD_PIN, 32'h0000_0000, 4'd0, 1'b1, 1'b1, 4'd0, 1'b0, 1'b1, 5'd15);
      add_row(CMD_PIN, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b1, 4'd1, 1'b0, 1'b1, 5'd14);
      // hit on a pinned frame
      add_row(CMD_PIN, 32'h0000_0000, 4'd0, 1'b1, 1'b1, 4'd0, 1'b1, 1'b0, 5'd14);
      // unpin down to zero, then once more on an empty frame
      add_row(CMD_UNPIN, 32'hA5A5_5A5A, 4'd0, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0, 5'd14);
      add_row(CMD_UNPIN, 32'h5A5A_A5A5, 4'd0, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0, 5'd15);
      add_row(CMD_UNPIN, 32'h0000_0000, 4'd0, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 5'd15);
      // block still resident in an unpinned frame: hit without a load
      add_row(CMD_PIN, 32'h0000_0000, 4'd0, 1'b1, 1'b1, 4'd0, 1'b1, 1'b0, 5'd14);
      // fill the remaining frames, checked by the model
      for (int k = 0; k < NUM_FRAMES - 2; k++)
         add_row(CMD_PIN, 32'h1 << (2 * k + 1), frame_idx_type'(k), 1'b0,
                 1'b0, 4'd0, 1'b0, 1'b0, 5'd0);
      // pool full: new block refused
      add_row(CMD_PIN, 32'h1234_5678, 4'd0, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 5'd0);
      // full pool still serves hits
      add_row(CMD_PIN, 32'hFFFF_FFFF, 4'd0, 1'b1, 1'b1, 4'd1, 1'b1, 1'b0, 5'd0);
      // release the top frame
      add_row(CMD_UNPIN, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1, 4'd15, 1'b0, 1'b0, 5'd1);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n])
         send_request(directed_rows[n].cmd, directed_rows[n].blk, directed_rows[n].idx,
                      directed_rows[n].typed, directed_rows[n].want, predicted);

      // pin one block until its count saturates, then unpin it past zero
      hammer_block = $urandom;
      send_request(CMD_PIN, hammer_block, '0, 1'b0, '0, got_first);
      hammer_frame = got_first.frame;
      for (int k = 0; k < 255; k++)
         send_request(CMD_PIN, hammer_block, frame_idx_type'($urandom), 1'b0, '0, predicted);
      for (int k = 0; k < 256; k++)
         send_request(CMD_UNPIN, $urandom, hammer_frame, 1'b0, '0, predicted);

      // random traffic under each idling mix
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = phase_idle[p];
         rsp_stall_pct   = phase_stall[p];
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick_random_request(cmd, blk, idx);
            send_request(cmd, blk, idx, 1'b0, '0, predicted);
         end
      end

      req_tvalid <= 1'b0;
      rsp_stall_pct = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items sent, %0d results checked in %0d cycles", items_sent, results_seen,
               cycle_count);
      $display("pins: %0d hits, %0d loads, %0d refused; unpins: %0d done, %0d refused",
               pin_hits, pin_loads, pins_refused, unpins_done, unpins_refused);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
